// ----- design/rgb_line_detect_convolution_top_macros.svh -----
`ifndef RGB_LINE_DETECT_CONVOLUTION_TOP_MACROS_SVH
`define RGB_LINE_DETECT_CONVOLUTION_TOP_MACROS_SVH

// Same-cycle implication check.
`define RLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rld check failed");

// Next-cycle implication check.
`define RLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rld check failed");

`endif

// ----- design/rld_pkg.sv -----
package rld_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MinWidth  = 5;
  localparam int unsigned RowWBits  = 13;
  localparam int unsigned ColBits   = 12;
  localparam int unsigned ScaleBits = 16;
  localparam int unsigned BiasBits  = 9;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SumBits   = 11;
  localparam int unsigned ProdBits  = 28;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CfgAddrW-1:0] RegRowWidth = 2'd0;
  localparam logic [CfgAddrW-1:0] RegScale    = 2'd1;
  localparam logic [CfgAddrW-1:0] RegBias     = 2'd2;

  localparam logic [RowWBits-1:0]  RowWidthRst = 13'd640;
  localparam logic [ScaleBits-1:0] ScaleRst    = 16'd256;
  localparam logic [BiasBits-1:0]  BiasRst     = 9'd0;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } px_t;

  typedef enum logic {
    JOB_SINGLE,
    JOB_BURST
  } job_kind_e;

  // seq[0..3] previous pixels, seq[4] current, seq[5..8] row head
  typedef struct packed {
    px_t [8:0]          seq;
    logic [ColBits-1:0] col;
    job_kind_e          kind;
  } job_t;

  typedef struct packed {
    logic empty;
    job_t job;
  } q_head_t;

endpackage

// ----- design/rld_fifo.sv -----
`include "rgb_line_detect_convolution_top_macros.svh"

module rld_fifo
  import rld_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_job_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.job   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  `RLD_ASSERT_NOW(a_no_overflow, push_i, !full_o)
  `RLD_ASSERT_NOW(a_no_underflow, pop_i, !head_o.empty)
  `RLD_ASSERT_NEXT(a_cnt_grows, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ----- design/rld_front.sv -----
module rld_front
  import rld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [RowWBits-1:0] row_width_i,
  input  logic                in_accept_i,
  input  px_t                 in_px_i,
  output logic                push_o,
  output job_t                push_job_o
);

  px_t                win_q  [4];
  px_t                head_q [4];
  logic [ColBits-1:0] cnt_q, cnt_d;

  logic [RowWBits-1:0] w_eff, w_m1, c_ext;
  logic [ColBits-1:0]  c;
  logic                last;

  always_comb begin
    if (row_width_i < RowWBits'(MinWidth)) begin
      w_eff = RowWBits'(MinWidth);
    end else if (row_width_i > RowWBits'(MaxWidth)) begin
      w_eff = RowWBits'(MaxWidth);
    end else begin
      w_eff = row_width_i;
    end
    w_m1  = w_eff - 1'b1;
    c_ext = ({1'b0, cnt_q} > w_m1) ? w_m1 : {1'b0, cnt_q};
    c     = c_ext[ColBits-1:0];
    last  = (c_ext == w_m1);

    push_o = in_accept_i && (last || c >= ColBits'(4));
    for (int j = 0; j < 4; j++) begin
      push_job_o.seq[j]     = win_q[j];
      push_job_o.seq[j + 5] = head_q[j];
    end
    push_job_o.seq[4] = in_px_i;
    if (last) begin
      push_job_o.kind = JOB_BURST;
      push_job_o.col  = ColBits'(w_eff - RowWBits'(3));
    end else begin
      push_job_o.kind = JOB_SINGLE;
      push_job_o.col  = c - ColBits'(2);
    end
    cnt_d = last ? '0 : c + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= in_px_i;
      if (c < ColBits'(4)) begin
        head_q[c[1:0]] <= in_px_i;
      end
    end
  end

endmodule

// ----- design/rld_back.sv -----
module rld_back
  import rld_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ScaleBits-1:0] scale_i,
  input  logic [BiasBits-1:0]  bias_i,
  input  q_head_t              head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ColBits-1:0]   out_col_o,
  output px_t                  out_px_o,
  output logic                 out_last_o
);

  function automatic logic signed [SumBits-1:0] line_sum(
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] m,
    input logic [7:0] d, input logic [7:0] e);
    logic signed [SumBits-1:0] s;
    s = $signed({1'b0, m, 2'b00}) - $signed({3'b000, a}) - $signed({3'b000, b})
      - $signed({3'b000, d}) - $signed({3'b000, e});
    return s;
  endfunction

  function automatic logic [7:0] clamp(input logic signed [ProdBits-1:0] v);
    logic [7:0] r;
    if (v[ProdBits-1] || v == '0) begin
      r = 8'd0;
    end else if (|v[ProdBits-1:16]) begin
      r = 8'hFF;
    end else begin
      r = v[15:8];
    end
    return r;
  endfunction

  logic       advance;
  logic [2:0] k_q, k_d;
  px_t        win [5];
  logic [3:0] idx;

  logic                      a_valid_q, a_valid_d;
  logic [ColBits-1:0]        a_col_q, a_col_d;
  logic                      a_last_q, a_last_d;
  logic signed [SumBits-1:0] a_sum_q [3];
  logic signed [SumBits-1:0] a_sum_d [3];

  logic                       b_valid_q;
  logic [ColBits-1:0]         b_col_q;
  logic                       b_last_q;
  logic signed [ProdBits-1:0] b_prod_q [3];
  logic signed [ProdBits-1:0] b_prod_d [3];
  logic signed [ProdBits-1:0] scale_ext, bias_ext;
  logic signed [ProdBits-1:0] v [3];

  logic               o_valid_q;
  logic [ColBits-1:0] o_col_q;
  px_t                o_px_q, o_px_d;
  logic               o_last_q;

  assign advance = !o_valid_q || out_ready_i;

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      idx    = 4'(k_q) + 4'(j);
      win[j] = head_i.job.seq[idx];
    end
    a_sum_d[0] = line_sum(win[0].red, win[1].red, win[2].red, win[3].red, win[4].red);
    a_sum_d[1] = line_sum(win[0].green, win[1].green, win[2].green, win[3].green,
                          win[4].green);
    a_sum_d[2] = line_sum(win[0].blue, win[1].blue, win[2].blue, win[3].blue,
                          win[4].blue);
    a_valid_d = !head_i.empty;
    if (head_i.job.kind == JOB_SINGLE) begin
      a_col_d  = head_i.job.col;
      a_last_d = 1'b1;
    end else begin
      a_col_d  = (k_q < 3'd3) ? head_i.job.col + ColBits'(k_q) : ColBits'(k_q - 3'd3);
      a_last_d = (k_q == 3'd4);
    end
    pop_o = advance && a_valid_d && a_last_d;
    if (pop_o) begin
      k_d = '0;
    end else if (advance && a_valid_d) begin
      k_d = k_q + 1'b1;
    end else begin
      k_d = k_q;
    end
  end

  always_comb begin
    scale_ext = $signed({{(ProdBits - ScaleBits){1'b0}}, scale_i});
    bias_ext  = $signed({{(ProdBits - BiasBits - 8){bias_i[BiasBits-1]}}, bias_i, 8'd0});
    for (int ch = 0; ch < 3; ch++) begin
      b_prod_d[ch] = $signed({{(ProdBits - SumBits){a_sum_q[ch][SumBits-1]}}, a_sum_q[ch]})
                     * scale_ext;
      v[ch] = b_prod_q[ch] + bias_ext;
    end
    o_px_d.red   = clamp(v[0]);
    o_px_d.green = clamp(v[1]);
    o_px_d.blue  = clamp(v[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (advance) begin
        a_valid_q <= a_valid_d;
        b_valid_q <= a_valid_q;
        o_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_col_q  <= a_col_d;
      a_last_q <= a_last_d;
      b_col_q  <= a_col_q;
      b_last_q <= a_last_q;
      o_col_q  <= b_col_q;
      o_last_q <= b_last_q;
      o_px_q   <= o_px_d;
      for (int ch = 0; ch < 3; ch++) begin
        a_sum_q[ch]  <= a_sum_d[ch];
        b_prod_q[ch] <= b_prod_d[ch];
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_col_o   = o_col_q;
  assign out_px_o    = o_px_q;
  assign out_last_o  = o_last_q;

endmodule

// ----- design/rgb_line_detect_convolution_top.sv -----
// RGB row line-detect filter.
// Input stream s_axis: one raster pixel per item, tdata = red, green, blue.
// Output stream m_axis: one filtered pixel per item, tdata = column, red,
// green, blue; tlast marks the last result caused by one input pixel.
// Each column x gives 4*P(x) minus its two neighbors on each side (columns
// wrap at the row width), scaled by an unsigned Q8.8 gain, offset by a signed
// bias, truncated toward zero and clamped to 0..255.
// The first four pixels of a row give no result; later pixels give the
// result for their column minus two; the last pixel of a row gives five.
// A result passes the job queue and the sum, product and output registers.
// Throughput: one item per cycle on both sides while the queue has room and
// m_axis_tready is high; a row end gives five output results, absorbed by a
// 4-entry job queue between the input tracker and the arithmetic pipeline.
// Configuration (cfg_we_i, cfg_addr_i, cfg_wdata_i) must be written only
// while idle (0 row width, 1 gain, 2 bias); the block does not enforce it.
// Reset clears the column counter, queue and pipeline and restores the
// register defaults (640, 1.0, 0). When m_axis_tready is low with a result
// pending, the output register holds and the pipeline stalls; s_axis_tready
// drops when the queue is full.
module rgb_line_detect_convolution_top
  import rld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // red, green, blue
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // column, out_red, out_green, out_blue, zeros
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [RowWBits-1:0]  row_width_q;
  logic [ScaleBits-1:0] scale_q;
  logic [BiasBits-1:0]  bias_q;

  logic               in_accept;
  logic               push;
  job_t               push_job;
  logic               full;
  logic               pop;
  q_head_t            head;
  logic [ColBits-1:0] out_col;
  px_t                out_px;
  px_t                in_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthRst;
      scale_q     <= ScaleRst;
      bias_q      <= BiasRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegRowWidth: row_width_q <= cfg_wdata_i[RowWBits-1:0];
        RegScale:    scale_q     <= cfg_wdata_i[ScaleBits-1:0];
        RegBias:     bias_q      <= cfg_wdata_i[BiasBits-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign in_accept     = s_axis_tvalid && !full;
  assign in_px.red     = s_axis_tdata[7:0];
  assign in_px.green   = s_axis_tdata[15:8];
  assign in_px.blue    = s_axis_tdata[23:16];

  rld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_width_i (row_width_q),
    .in_accept_i (in_accept),
    .in_px_i     (in_px),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  rld_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head)
  );

  rld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .bias_i      (bias_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_col_o   (out_col),
    .out_px_o    (out_px),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_px.blue, out_px.green, out_px.red, out_col};

endmodule

// ----- bench/rgb_line_detect_convolution_top_test.sv -----
module rgb_line_detect_convolution_top_test;
  import rld_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomPixels = 210;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [ColBits-1:0] col;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } filt_px_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;  // red, green, blue
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;  // column, out_red, out_green, out_blue, zeros
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rgb_line_detect_convolution_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // filter state as the block should hold it
  logic [RowWBits-1:0]         width_reg = RowWidthRst;
  logic [ScaleBits-1:0]        gain_reg  = ScaleRst;
  logic signed [BiasBits-1:0]  bias_reg  = BiasRst;
  px_t                         head_px [4];
  px_t                         recent_px [4];
  int unsigned                 next_col = 0;

  filt_px_t    expected_pixels [$];
  int unsigned mismatches  = 0;
  int unsigned pixels_in   = 0;
  int unsigned results_out = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_wait   = 0;
  bit          src_calm    = 0;
  bit          sink_calm   = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_pixels.size());
      $display("rgb_line_detect_convolution_top_test: errors");
      $finish;
    end
  end

  function automatic logic [7:0] line_lane(input logic [7:0] m2, m1, c0, p1, p2);
    longint s;
    longint v;
    s = 4 * longint'(c0) - longint'(m2) - longint'(m1) - longint'(p1) - longint'(p2);
    v = s * longint'(gain_reg) + longint'(bias_reg) * 256;
    if (v <= 0) return 8'd0;
    v = v / 256;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic void predict_line_filter(input px_t cur);
    int unsigned w;
    int unsigned c;
    int unsigned n;
    int unsigned col;
    px_t         seq [9];
    filt_px_t    e;
    bit          row_end;
    w = width_reg;
    if (w < MinWidth) w = MinWidth;
    if (w > MaxWidth) w = MaxWidth;
    c = next_col;
    if (c > w - 1) c = w - 1;
    row_end = (c == w - 1);
    for (int k = 0; k < 4; k++) begin
      seq[k]     = recent_px[k];
      seq[k + 5] = head_px[k];
    end
    seq[4] = cur;
    n = row_end ? 5 : (c >= 4 ? 1 : 0);
    for (int k = 0; k < n; k++) begin
      if (row_end) begin
        col = w - 3 + k;
        if (col >= w) col -= w;
      end else begin
        col = c - 2;
      end
      e.col   = col[ColBits-1:0];
      e.red   = line_lane(seq[k].red, seq[k+1].red, seq[k+2].red, seq[k+3].red,
                          seq[k+4].red);
      e.green = line_lane(seq[k].green, seq[k+1].green, seq[k+2].green,
                          seq[k+3].green, seq[k+4].green);
      e.blue  = line_lane(seq[k].blue, seq[k+1].blue, seq[k+2].blue, seq[k+3].blue,
                          seq[k+4].blue);
      e.last  = (k == n - 1);
      expected_pixels.push_back(e);
    end
    if (c < 4) head_px[c] = cur;
    for (int k = 0; k < 3; k++) recent_px[k] = recent_px[k + 1];
    recent_px[3] = cur;
    next_col = row_end ? 0 : c + 1;
  endfunction

  // result side: random stalls and the comparison
  always @(posedge clk_i) begin : result_check
    filt_px_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_out++;
      if (results_out % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: column %0d", m_axis_tdata[11:0]);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[11:0] !== want.col) begin
          $error("column: expected %0d, got %0d", want.col, m_axis_tdata[11:0]);
          mismatches++;
        end
        if (m_axis_tdata[19:12] !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, m_axis_tdata[19:12]);
          mismatches++;
        end
        if (m_axis_tdata[27:20] !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, m_axis_tdata[27:20]);
          mismatches++;
        end
        if (m_axis_tdata[35:28] !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, m_axis_tdata[35:28]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
      sink_wait = sink_calm ? 0 : $urandom_range(0, 5);
    end
    if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic px_t mk_px(input logic [7:0] r, g, b);
    px_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  function automatic logic [7:0] rand_chan();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic px_t rand_px();
    return mk_px(rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic send_pixel(input px_t p);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_line_filter(p);
    pixels_in++;
    if (pixels_in % 32 == 0) src_calm = ($urandom_range(0, 3) == 0);
  endtask

  // called in the step of the last accepted pixel, so tvalid drops at once
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [RowWBits-1:0] width,
                               input logic [ScaleBits-1:0] gain,
                               input logic [BiasBits-1:0] bias);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegRowWidth;
    cfg_wdata_i <= CfgDataW'(width);
    @(posedge clk_i);
    cfg_addr_i  <= RegScale;
    cfg_wdata_i <= CfgDataW'(gain);
    @(posedge clk_i);
    cfg_addr_i  <= RegBias;
    cfg_wdata_i <= CfgDataW'(bias);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg = width;
    gain_reg  = gain;
    bias_reg  = bias;
  endtask

  // reset defaults, then a narrower width lands mid-row
  task automatic test_defaults_and_shrink();
    send_pixel(mk_px(8'hFF, 8'h00, 8'hFF));
    send_pixel(mk_px(8'h00, 8'hFF, 8'h00));
    send_pixel(mk_px(8'hFF, 8'hFF, 8'h00));
    send_pixel(mk_px(8'h00, 8'h00, 8'hFF));
    send_pixel(mk_px(8'h80, 8'h01, 8'hFE));
    drain_results();
    load_settings(13'd0, 16'd256, 9'd0);  // below minimum, acts as 5
    send_pixel(mk_px(8'h00, 8'hFF, 8'h7F));
    drain_results();
  endtask

  task automatic test_gain_extremes();
    load_settings(13'd5, 16'hFFFF, 9'sd255);
    send_pixel(mk_px(8'h00, 8'hFF, 8'h00));
    send_pixel(mk_px(8'h00, 8'h00, 8'h00));
    send_pixel(mk_px(8'hFF, 8'h00, 8'h01));
    send_pixel(mk_px(8'h00, 8'hFF, 8'h00));
    send_pixel(mk_px(8'h00, 8'h00, 8'hFF));
    drain_results();
    load_settings(13'd5, 16'd0, -9'sd255);
    repeat (5) send_pixel(mk_px(8'hFF, 8'hFF, 8'hFF));
    drain_results();
    load_settings(13'd5, 16'd256, 9'h100);  // bias -256
    repeat (5) send_pixel(mk_px(8'hFF, 8'h00, 8'hFF));
    drain_results();
  endtask

  task automatic test_oversize_width();
    load_settings(13'h1FFF, 16'd256, 9'd0);  // above maximum, acts as 4096
    repeat (5) send_pixel(rand_px());
    drain_results();
    load_settings(13'd5, 16'd256, 9'd3);
    send_pixel(rand_px());
    drain_results();
  endtask

  // widest setting, row cut short by a narrower width
  task automatic test_widest_row();
    load_settings(13'(MaxWidth), 16'($urandom_range(128, 512)), 9'($urandom));
    repeat (20) send_pixel(rand_px());
    drain_results();
    load_settings(13'd9, 16'd256, 9'd0);
    send_pixel(rand_px());
    drain_results();
  endtask

  task automatic test_random_rows();
    int unsigned sent;
    int unsigned n;
    logic [RowWBits-1:0]  w;
    logic [ScaleBits-1:0] g;
    sent = 0;
    while (sent < RandomPixels) begin
      case ($urandom_range(0, 9))
        0:       w = RowWBits'($urandom_range(0, 4));
        1:       w = RowWBits'($urandom_range(13, 40));
        default: w = RowWBits'($urandom_range(5, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       g = '0;
        1:       g = '1;
        2:       g = ScaleBits'($urandom);
        default: g = ScaleBits'($urandom_range(64, 768));
      endcase
      load_settings(w, g, BiasBits'($urandom));
      n = $urandom_range(8, 40);
      repeat (n) send_pixel(rand_px());
      drain_results();
      sent += n;
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= RegRowWidth;
    cfg_wdata_i   <= '0;
    foreach (head_px[k]) head_px[k] = '0;
    foreach (recent_px[k]) recent_px[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_shrink();
    test_gain_extremes();
    test_oversize_width();
    test_widest_row();
    test_random_rows();

    $display("pixels sent %0d, filtered results checked %0d, cycles %0d",
             pixels_in, results_out, cycle_count);
    $display("row widths 0..8191 incl. mid-row shrink, gain 0..65535, bias -256..255");
    if (mismatches == 0) begin
      $display("rgb_line_detect_convolution_top_test: clean");
    end else begin
      $display("rgb_line_detect_convolution_top_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/rld_pkg.sv
design/rld_fifo.sv
design/rld_front.sv
design/rld_back.sv
design/rgb_line_detect_convolution_top.sv
bench/rgb_line_detect_convolution_top_test.sv
